### sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/lpfd_pkg.sv
package lpfd_pkg;

    localparam int FRAME_LIMIT_DEF = 65536;

    localparam logic [16:0] COUNT_LIMIT = 17'd100000;
    localparam logic [16:0] WORD_BYTES  = 17'd4;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_DISCARD = 2'd2
    } byte_kind_t;

    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_TRUNC_LEN   = 3'd1,
        ERR_BAD_COUNT   = 3'd2,
        ERR_TRUNC_FIELD = 3'd3,
        ERR_TRAILING    = 3'd4
    } error_code_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [16:0] frame_bytes;
    } byte_item_t;

    typedef struct packed {
        logic [7:0]  byte_out;
        logic [1:0]  byte_kind;
        logic [16:0] field_number;
        logic        length_ready;
        logic [16:0] field_bytes;
        logic        field_end;
        logic        count_ready;
        logic [16:0] field_total;
        logic        frame_end;
        logic [2:0]  error_code;
    } result_item_t;

endpackage

### sv/lpfd_chan_if.sv
interface lpfd_chan_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### sv/length_prefixed_field_deframer_unit.sv
// Channel   Role   Payload
// stream    sink   data_byte, frame_bytes
// result    source byte_out, byte_kind, field_number, length_ready, field_bytes,
//                  field_end, count_ready, field_total, frame_end, error_code
// cfg       sink   max_field_count (always ready)
//
// One byte per cycle sustained while the result side takes items; a byte passes
// from the input register, through one pass of parse logic, into the result
// register once that register is free.
// The pace is set by the parse state update, which runs once per byte.
// Reset clears the parse state and sets max_field_count to 100000.
// A stalled result holds the byte in the input register; the input side
// stalls only while both registers are full and the result is not taken.
`include "assert_macros.svh"

module length_prefixed_field_deframer_unit
    import lpfd_pkg::*;
#(
    parameter int FRAME_LIMIT = FRAME_LIMIT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    lpfd_chan_if.sink   stream,
    lpfd_chan_if.source result,
    lpfd_chan_if.sink   cfg
);

    typedef enum logic [1:0] {
        PH_COUNT   = 2'd0,
        PH_LENGTH  = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_DISCARD = 2'd3
    } phase_t;

    // Frame lengths only reach 17 bits, so a larger limit never clips.
    localparam logic [16:0] MAX_LEN = (FRAME_LIMIT > 131071) ? 17'h1FFFF : 17'(FRAME_LIMIT);

    logic         in_vld_reg;
    byte_item_t   in_reg;
    logic         out_vld_reg;
    result_item_t out_reg;
    logic [16:0]  max_count_reg;

    phase_t       phase_reg, phase_next;
    logic [16:0]  pos_reg, pos_next;
    logic [1:0]   idx_reg, idx_next;
    logic [31:0]  acc_reg, acc_next;
    logic [16:0]  fields_left_reg, fields_left_next;
    logic [16:0]  payload_left_reg, payload_left_next;
    logic [16:0]  cur_field_reg, cur_field_next;

    logic         advance;
    logic [16:0]  len;
    logic [17:0]  pos_inc;
    logic         last;
    logic [16:0]  rem;
    logic [16:0]  avail;
    logic [31:0]  word;
    logic [16:0]  payload_dec;
    result_item_t res;
    error_code_t  err;

    assign advance      = in_vld_reg && (!out_vld_reg || result.ready);
    assign stream.ready = !in_vld_reg || advance;
    assign result.valid = out_vld_reg;
    assign result.data  = out_reg;
    assign cfg.ready    = 1'b1;

    always_comb
    begin
        len = (in_reg.frame_bytes == 17'd0) ? 17'd1 : in_reg.frame_bytes;
        if (len > MAX_LEN)
        begin
            len = MAX_LEN;
        end
        pos_inc = {1'b0, pos_reg} + 18'd1;
        last    = pos_inc >= {1'b0, len};
        rem     = (pos_reg < len) ? len - pos_reg : 17'd0;
        avail   = (pos_inc < {1'b0, len}) ? len - pos_inc[16:0] : 17'd0;
        word    = {acc_reg[23:0], in_reg.data_byte};
        payload_dec = (payload_left_reg != 17'd0) ? payload_left_reg - 17'd1 : 17'd0;

        phase_next        = phase_reg;
        pos_next          = pos_reg;
        idx_next          = idx_reg;
        acc_next          = acc_reg;
        fields_left_next  = fields_left_reg;
        payload_left_next = payload_left_reg;
        cur_field_next    = cur_field_reg;
        err               = ERR_NONE;

        res              = '0;
        res.byte_out     = in_reg.data_byte;
        res.byte_kind    = KIND_HEADER;
        res.field_number = cur_field_reg;

        if (phase_reg == PH_DISCARD)
        begin
            res.byte_kind = KIND_DISCARD;
        end
        else if (phase_reg == PH_PAYLOAD)
        begin
            res.byte_kind     = KIND_PAYLOAD;
            payload_left_next = payload_dec;
            if (payload_dec == 17'd0)
            begin
                res.field_end    = 1'b1;
                fields_left_next = (fields_left_reg != 17'd0) ? fields_left_reg - 17'd1
                                                              : 17'd0;
                cur_field_next   = cur_field_reg + 17'd1;
                phase_next       = PH_LENGTH;
            end
        end
        else if (phase_reg == PH_LENGTH && fields_left_reg == 17'd0)
        begin
            err = ERR_TRAILING;
        end
        else if (idx_reg == 2'd0 && rem < WORD_BYTES)
        begin
            err = ERR_TRUNC_LEN;
        end
        else
        begin
            acc_next = word;
            idx_next = idx_reg + 2'd1;
            if (idx_reg == 2'd3)
            begin
                acc_next = '0;
                if (phase_reg == PH_COUNT)
                begin
                    // The count may claim at most one length word per four bytes left.
                    if (word > {15'd0, COUNT_LIMIT} || word > {15'd0, max_count_reg} ||
                        word > {17'd0, avail[16:2]})
                    begin
                        err = ERR_BAD_COUNT;
                    end
                    else
                    begin
                        res.count_ready  = 1'b1;
                        res.field_total  = word[16:0];
                        fields_left_next = word[16:0];
                        phase_next       = PH_LENGTH;
                    end
                end
                else if (word > {15'd0, avail})
                begin
                    err = ERR_TRUNC_FIELD;
                end
                else
                begin
                    res.length_ready = 1'b1;
                    res.field_bytes  = word[16:0];
                    if (word == 32'd0)
                    begin
                        res.field_end    = 1'b1;
                        fields_left_next = fields_left_reg - 17'd1;
                        cur_field_next   = cur_field_reg + 17'd1;
                    end
                    else
                    begin
                        payload_left_next = word[16:0];
                        phase_next        = PH_PAYLOAD;
                    end
                end
            end
        end

        // The last byte must leave the parse complete: all fields done, no partial word.
        if (err == ERR_NONE && last && phase_next != PH_DISCARD &&
            !(phase_next == PH_LENGTH && fields_left_next == 17'd0 && idx_next == 2'd0))
        begin
            err = (phase_next == PH_PAYLOAD) ? ERR_TRUNC_FIELD : ERR_TRUNC_LEN;
        end

        if (err != ERR_NONE)
        begin
            phase_next       = PH_DISCARD;
            res.byte_kind    = KIND_DISCARD;
            res.length_ready = 1'b0;
            res.field_bytes  = '0;
            res.field_end    = 1'b0;
            res.count_ready  = 1'b0;
            res.field_total  = '0;
        end
        res.error_code = err;
        res.frame_end  = last;

        if (last)
        begin
            phase_next        = PH_COUNT;
            pos_next          = '0;
            idx_next          = '0;
            acc_next          = '0;
            fields_left_next  = '0;
            payload_left_next = '0;
            cur_field_next    = '0;
        end
        else
        begin
            pos_next = pos_inc[16:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg       <= 1'b0;
            out_vld_reg      <= 1'b0;
            out_reg          <= '0;
            max_count_reg    <= COUNT_LIMIT;
            phase_reg        <= PH_COUNT;
            pos_reg          <= '0;
            idx_reg          <= '0;
            acc_reg          <= '0;
            fields_left_reg  <= '0;
            payload_left_reg <= '0;
            cur_field_reg    <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                max_count_reg <= cfg.data;
            end
            if (stream.ready)
            begin
                in_vld_reg <= stream.valid;
            end
            if (advance)
            begin
                out_vld_reg      <= 1'b1;
                out_reg          <= res;
                phase_reg        <= phase_next;
                pos_reg          <= pos_next;
                idx_reg          <= idx_next;
                acc_reg          <= acc_next;
                fields_left_reg  <= fields_left_next;
                payload_left_reg <= payload_left_next;
                cur_field_reg    <= cur_field_next;
            end
            else if (result.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stream.valid && stream.ready)
        begin
            in_reg <= stream.data;
        end
    end

    `ASSERT_NEXT(a_frame_end_clears, clk, rst_n, advance && last,
        phase_reg == PH_COUNT && pos_reg == 17'd0 && cur_field_reg == 17'd0,
        "parse state not cleared after the last byte of a frame")
    `ASSERT_NEXT(a_discard_sticks, clk, rst_n,
        advance && phase_reg == PH_DISCARD && !last, phase_reg == PH_DISCARD,
        "discard phase left before the end of the frame")
    `ASSERT_SAME(a_word_aligned, clk, rst_n,
        phase_reg == PH_PAYLOAD || phase_reg == PH_DISCARD, idx_reg == 2'd0,
        "partial word pending outside the header phases")
    `ASSERT_SAME(a_one_word_report, clk, rst_n, out_vld_reg,
        !(out_reg.count_ready && out_reg.length_ready),
        "count and length reported on the same item")
    `ASSERT_SAME(a_error_discards, clk, rst_n,
        out_vld_reg && out_reg.error_code != ERR_NONE, out_reg.byte_kind == KIND_DISCARD,
        "item with an error not tagged as discarded")

endmodule
